>>> hw/rtl/tnrx_pkg.sv
// Shared constants and types for the telnet receive filter.
package tnrx_pkg;

	// Telnet command bytes
	localparam logic [7:0] TN_IAC  = 8'd255;
	localparam logic [7:0] TN_DONT = 8'd254;
	localparam logic [7:0] TN_DO   = 8'd253;
	localparam logic [7:0] TN_WONT = 8'd252;
	localparam logic [7:0] TN_WILL = 8'd251;
	localparam logic [7:0] TN_SB   = 8'd250;
	localparam logic [7:0] TN_SE   = 8'd240;

	// Control characters seen by the normalizer
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;

	// Values of the action flag carried in tuser
	localparam logic ACT_DATA    = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	// Command parser state, one-hot
	typedef enum logic [4:0] {
		MODE_NORMAL = 5'b00001,
		MODE_CMD    = 5'b00010,
		MODE_OPT    = 5'b00100,
		MODE_SB     = 5'b01000,
		MODE_SB_IAC = 5'b10000
	} parse_mode_t;

endpackage

>>> hw/rtl/telnet_rx_filter_newline_normalizer_unit.sv
// Telnet receive filter: strips telnet commands and normalizes newlines.
//
// Takes one received byte per transaction on the slave stream and gives at
// most one cleaned byte per transaction on the master stream. A bad byte
// never comes out: commands (IAC x, IAC WILL/WONT/DO/DONT opt, IAC SB ... IAC
// SE) are removed, IAC IAC yields a literal 255, CR passes, LF right after CR
// is dropped, a lone LF becomes CR, NUL is dropped and DEL becomes backspace.
// Bytes swallowed by the command parser leave the CR memory untouched. A
// transaction with tuser set is a session restart: it clears the parser and
// the CR memory and gives no output. The block takes one transaction every
// cycle while s_axis_tready is high: a byte is held in an input register,
// decoded by a few gates against the parser state, and the result is
// registered in the output register that drives the master stream.
// Input and output are parted by that output register; the only stall is a
// full output register whose byte is not being taken, and that holds the
// input register (s_axis_tready falls) until the master side drains.
module telnet_rx_filter_newline_normalizer_unit
	import tnrx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] raw_byte
	input  logic       s_axis_tuser,   // [0] action (1 = session restart)

	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [7:0] clean_byte
);

	// Input register
	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  byte_s1;

	// Parser and normalizer state
	parse_mode_t mode_q;
	logic        last_cr_q;

	// Output register
	logic        out_valid_q;
	logic [7:0]  out_data_q;

	// Next-state and result of the byte in the input register
	parse_mode_t mode_d;
	logic        last_cr_d;
	logic        is_data;
	logic        emit;
	logic [7:0]  emit_byte;
	logic        advance;

	// Retire the held byte when the output register is free or draining.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload needs no reset; load it on each accepted transaction.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= s_axis_tuser;
			byte_s1   <= s_axis_tdata;
		end
	end

	// Command parser, then newline normalization of surviving data bytes.
	always_comb begin
		mode_d    = mode_q;
		last_cr_d = last_cr_q;
		is_data   = 1'b0;
		emit      = 1'b0;
		emit_byte = byte_s1;

		if (action_s1 == ACT_RESTART) begin
			mode_d    = MODE_NORMAL;
			last_cr_d = 1'b0;
		end else begin
			case (mode_q)
				MODE_CMD: begin
					if (byte_s1 == TN_IAC) begin
						// doubled IAC: literal 255
						mode_d  = MODE_NORMAL;
						is_data = 1'b1;
					end else if (byte_s1 inside {TN_WILL, TN_WONT, TN_DO, TN_DONT}) begin
						mode_d = MODE_OPT;
					end else if (byte_s1 == TN_SB) begin
						mode_d = MODE_SB;
					end else begin
						mode_d = MODE_NORMAL;
					end
				end
				MODE_OPT: begin
					// drop the option byte
					mode_d = MODE_NORMAL;
				end
				MODE_SB: begin
					if (byte_s1 == TN_IAC) begin
						mode_d = MODE_SB_IAC;
					end
				end
				MODE_SB_IAC: begin
					mode_d = (byte_s1 == TN_SE) ? MODE_NORMAL : MODE_SB;
				end
				default: begin
					if (byte_s1 == TN_IAC) begin
						mode_d = MODE_CMD;
					end else begin
						mode_d  = MODE_NORMAL;
						is_data = 1'b1;
					end
				end
			endcase

			if (is_data) begin
				case (byte_s1)
					CH_CR: begin
						last_cr_d = 1'b1;
						emit      = 1'b1;
						emit_byte = CH_CR;
					end
					CH_LF: begin
						// LF after CR is dropped; a lone LF turns into CR
						last_cr_d = 1'b0;
						emit      = !last_cr_q;
						emit_byte = CH_CR;
					end
					CH_NUL: begin
						last_cr_d = 1'b0;
					end
					CH_DEL: begin
						last_cr_d = 1'b0;
						emit      = 1'b1;
						emit_byte = CH_BS;
					end
					default: begin
						last_cr_d = 1'b0;
						emit      = 1'b1;
						emit_byte = byte_s1;
					end
				endcase
			end
		end
	end

	// Advance the parser state only when the held byte retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			last_cr_q <= 1'b0;
		end else if (advance) begin
			mode_q    <= mode_d;
			last_cr_q <= last_cr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= emit_byte;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

>>> hw/rtl/tnrx_checker.sv
// Port-level checks for the telnet receive filter, bound to the top level.
module tnrx_checker
	import tnrx_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tuser,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	// A waiting input transaction holds its byte and action.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
		else $error("input transaction changed while waiting");

	// A stalled output transaction holds its byte.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output byte changed while stalled");

	// An empty output register never stalls the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// Normalization never lets NUL or LF through.
	a_no_nul_lf: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata != CH_NUL) && (m_axis_tdata != CH_LF))
		else $error("NUL or LF on output");

	// DEL always leaves as backspace.
	a_no_del: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata != CH_DEL)
		else $error("DEL on output");

endmodule

bind telnet_rx_filter_newline_normalizer_unit tnrx_checker u_tnrx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
